@@ rtl/core/ials_pkg.sv @@
// ----------------------------------------------------------------------------
// ials_pkg: shared types and constants for the indexed array list engine
// Store depth, field layouts of the request and response beats, request
// codes, status codes and the command broadcast to the row of cells.
// ----------------------------------------------------------------------------
package ials_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   // Width used for all index and count comparisons; covers the 7-bit fields.
   localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
   localparam int WORD_W = 32;

   typedef enum logic [3:0] {
      ACT_PUSH   = 4'd0,
      ACT_POP    = 4'd1,
      ACT_INSERT = 4'd2,
      ACT_ERASE  = 4'd3,
      ACT_READ   = 4'd4,
      ACT_WRITE  = 4'd5,
      ACT_CLEAR  = 4'd6,
      ACT_RESIZE = 4'd7,
      ACT_ASSIGN = 4'd8
   } act_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_EMPTY = 2'd3
   } stat_type;

   typedef struct packed {
      logic [3:0]               action;
      logic [5:0]               position;
      logic signed [WORD_W-1:0] value;
      logic [6:0]               new_size;
   } ials_req_type;

   typedef struct packed {
      stat_type                 status;
      logic signed [WORD_W-1:0] read_value;
      logic [6:0]               count;
      logic                     is_empty;
   } ials_rsp_type;

   typedef struct packed {
      logic                     en;
      logic [3:0]               action;
      logic [CMP_W-1:0]         pos;
      logic [CMP_W-1:0]         cnt;
      logic [CMP_W-1:0]         nsz;
      logic signed [WORD_W-1:0] value;
   } ials_cmd_type;

endpackage

@@ rtl/core/ials_cell.sv @@
// ----------------------------------------------------------------------------
// ials_cell: one entry of the list
// Holds one word and, under the broadcast command, keeps it, loads the new
// value, or takes the word of its lower or upper neighbor. Drives its word
// onto the read tap when it is the addressed entry of a read.
// ----------------------------------------------------------------------------
module ials_cell (
   input  logic                              clock,
   input  logic [ials_pkg::IDX_W-1:0]        cell_idx,
   input  ials_pkg::ials_cmd_type            cmd,
   input  logic signed [ials_pkg::WORD_W-1:0] left_word,
   input  logic signed [ials_pkg::WORD_W-1:0] right_word,
   output logic signed [ials_pkg::WORD_W-1:0] word_out,
   output logic signed [ials_pkg::WORD_W-1:0] tap_word
);
   import ials_pkg::*;

   logic signed [WORD_W-1:0] word_ff;
   logic signed [WORD_W-1:0] word_in;
   logic [CMP_W-1:0]         idx;
   logic                     sel;

   assign idx = CMP_W'(cell_idx);

   always_comb begin
      word_in = word_ff;
      sel     = 1'b0;
      if (cmd.en) begin
         case (cmd.action)
            ACT_PUSH: begin
               if (idx == cmd.cnt) word_in = cmd.value;
            end
            ACT_INSERT: begin
               if (idx == cmd.pos) begin
                  word_in = cmd.value;
               end else if (idx > cmd.pos && idx <= cmd.cnt) begin
                  word_in = left_word;
               end
            end
            ACT_ERASE: begin
               if (idx >= cmd.pos && (idx + CMP_W'(1)) < cmd.cnt) word_in = right_word;
            end
            ACT_READ: begin
               sel = (idx == cmd.pos);
            end
            ACT_WRITE: begin
               if (idx == cmd.pos) word_in = cmd.value;
            end
            ACT_RESIZE: begin
               if (idx >= cmd.cnt && idx < cmd.nsz) word_in = cmd.value;
            end
            ACT_ASSIGN: begin
               if (idx < cmd.nsz) word_in = cmd.value;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;
   assign tap_word = sel ? word_ff : '0;

endmodule

@@ rtl/core/indexed_array_list_engine.sv @@
// ----------------------------------------------------------------------------
// indexed_array_list_engine: ordered list of signed words in a row of cells
// Push, pop, insert, erase, read, write, clear, resize and assign on a list
// of up to DEPTH words, one cell per entry, with a count of entries in use.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. Its response
// is driven on the rsp_ ports with rsp_strobe high for exactly one cycle,
// once the request has passed the EXEC and FIN states. It cannot be held
// off, so the receiver must take it at the edge that ends that cycle. busy
// is low again in the strobe cycle, so a new request is taken only after the
// last one has reached its strobe cycle. In EXEC every cell updates in
// parallel (shifting from a neighbor or comparing its own index) and the
// first stage of the OR tree that gathers a read word is registered. FIN
// runs the second stage of that tree into the response register. The store
// is not cleared at reset; only the count is.
module indexed_array_list_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ials_pkg::ials_req_type req_item,
   output logic                   rsp_strobe,
   output ials_pkg::ials_rsp_type rsp_item
);
   import ials_pkg::*;

   localparam int GRP  = 8;
   localparam int NGRP = (DEPTH + GRP - 1) / GRP;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FIN
   } state_type;

   state_type                state_ff;
   ials_req_type             cmd_ff;
   stat_type                 status_ff;
   stat_type                 status_in;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic signed [WORD_W-1:0] grp_ff [NGRP];
   logic signed [WORD_W-1:0] grp_in [NGRP];
   logic signed [WORD_W-1:0] rd_word;
   ials_rsp_type             rsp_ff;
   logic                     rsp_strobe_ff;
   ials_cmd_type             cell_cmd;
   logic [CMP_W-1:0]         pos;
   logic [CMP_W-1:0]         cnt;
   logic [CMP_W-1:0]         nsz;
   logic                     ok;

   logic signed [WORD_W-1:0] words [DEPTH];
   logic signed [WORD_W-1:0] taps  [DEPTH];

   assign pos = CMP_W'(cmd_ff.position);
   assign cnt = CMP_W'(count_ff);
   assign nsz = CMP_W'(cmd_ff.new_size);

   // Status and next count of the request held in cmd_ff.
   always_comb begin
      status_in = STAT_OK;
      case (cmd_ff.action)
         ACT_PUSH: begin
            if (cnt >= CMP_W'(DEPTH)) status_in = STAT_FULL;
         end
         ACT_POP: begin
            if (cnt == '0) status_in = STAT_EMPTY;
         end
         ACT_INSERT: begin
            if (pos > cnt) begin
               status_in = STAT_RANGE;
            end else if (cnt >= CMP_W'(DEPTH)) begin
               status_in = STAT_FULL;
            end
         end
         ACT_ERASE, ACT_READ, ACT_WRITE: begin
            if (pos >= cnt) status_in = STAT_RANGE;
         end
         ACT_RESIZE, ACT_ASSIGN: begin
            if (nsz > CMP_W'(DEPTH)) status_in = STAT_FULL;
         end
         default: begin
         end
      endcase
      ok = (status_in == STAT_OK);

      count_in = count_ff;
      if (ok) begin
         case (cmd_ff.action)
            ACT_PUSH, ACT_INSERT:  count_in = count_ff + CNT_W'(1);
            ACT_POP, ACT_ERASE:    count_in = count_ff - CNT_W'(1);
            ACT_CLEAR:             count_in = '0;
            ACT_RESIZE, ACT_ASSIGN: count_in = CNT_W'(cmd_ff.new_size);
            default:               count_in = count_ff;
         endcase
      end
   end

   always_comb begin
      cell_cmd.en     = (state_ff == ST_EXEC) && ok;
      cell_cmd.action = cmd_ff.action;
      cell_cmd.pos    = pos;
      cell_cmd.cnt    = cnt;
      cell_cmd.nsz    = nsz;
      cell_cmd.value  = cmd_ff.value;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [WORD_W-1:0] left_w;
      logic signed [WORD_W-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = words[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = words[i+1];
      end

      ials_cell u_cell (
         .clock      (clock),
         .cell_idx   (IDX_W'(i)),
         .cmd        (cell_cmd),
         .left_word  (left_w),
         .right_word (right_w),
         .word_out   (words[i]),
         .tap_word   (taps[i])
      );
   end

   // First stage of the read tree: OR the taps of each group of cells.
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GRP; k++) begin
            if (g * GRP + k < DEPTH) grp_in[g] = grp_in[g] | taps[g*GRP + k];
         end
      end
   end

   always_comb begin
      rd_word = '0;
      for (int g = 0; g < NGRP; g++) begin
         rd_word = rd_word | grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  cmd_ff   <= req_item;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               status_ff <= status_in;
               count_ff  <= count_in;
               grp_ff    <= grp_in;
               state_ff  <= ST_FIN;
            end
            ST_FIN: begin
               rsp_ff.status     <= status_ff;
               rsp_ff.read_value <= rd_word;
               rsp_ff.count      <= 7'(count_ff);
               rsp_ff.is_empty   <= (count_ff == '0);
               rsp_strobe_ff     <= 1'b1;
               state_ff          <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(DEPTH))
      else $error("entry count above depth");

   a_strobe_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> state_ff == ST_IDLE)
      else $error("response beat while a request is still in flight");

   a_empty_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_item.is_empty == (rsp_item.count == 7'd0))
      else $error("empty flag disagrees with count");

   a_fail_keeps_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status != STAT_OK) |-> rsp_item.count == 7'($past(count_ff, 2)))
      else $error("failed request changed the count");

   a_read_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.read_value != '0) |-> rsp_item.status == STAT_OK)
      else $error("read word returned on a failed request");

endmodule
